// ----- rtl/ftk_pkg.sv -----
// Shared types, constants and the fp16 rank function of the top-k selector.
`default_nettype none

package ftk_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_K_COUNT      = 8'd0;
  localparam logic [7:0] REG_SORTED_ORDER = 8'd1;

  // Field widths fixed by the item format
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned KCNT_W = 7;
  localparam int unsigned OPOS_W = 10;

  // Per-cycle command to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SORT_EVEN,
    OP_SORT_ODD,
    OP_SHIFT_OUT
  } ftk_op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SORT,
    ST_EMIT
  } ftk_state_e;

  // Broadcast to the cells
  typedef struct packed {
    ftk_op_e             op;
    logic [KCNT_W-1:0]   k_eff;
    logic [VAL_W-1:0]    new_value;
    logic [KEY_W-1:0]    new_key;
  } ftk_ctrl_t;

  // Monotone key: larger key is a larger number, NaN lowest, both zeros equal
  function automatic logic [KEY_W-1:0] rank_key(input logic [VAL_W-1:0] v);
    logic [14:0] mag;
    logic [KEY_W-1:0] res;
    mag = v[14:0];
    if (mag > 15'h7C00) begin
      res = '0;
    end else if (v[15]) begin
      res = 16'h8000 - {1'b0, mag};
    end else begin
      res = 16'h8000 + {1'b0, mag};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fp16_topk_select_top.sv -----
// Top level of the fp16 top-k selector: controller, configuration and the cell chain.
//
// Channel   Dir   Handshake                    Payload
// s_axis    in    s_axis_tvalid/s_axis_tready  tdata[15:0] sample_value, tlast last_in_row
// m_axis    out   m_axis_tvalid/m_axis_tready  tdata[15:0] top_value, [25:16] top_position,
//                                              tlast run_end
// cfg       in    cfg_valid_i/cfg_ready_o      cfg_index_i register, cfg_data_i value
//
// Row elements are taken one per cycle; each is ranked into the cell chain in that cycle.
// After the last element of a row, ascending-position mode runs an odd-even transposition
// sort across the cells (n = results of the row), then n results follow,
// one per cycle while m_axis_tready is high; no input is taken from row end until the
// last result leaves. Reset empties the list at once, with no clearing pass.
// Output stalls hold the head cell and the result count.
`default_nettype none

module fp16_topk_select_top #(
  parameter int unsigned MAX_K   = 64,
  parameter int unsigned MAX_ROW = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] sample_value
  input  wire         s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] top_value, [25:16] top_position, [31:26] zero
  output logic        m_axis_tlast,
  // configuration writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_index_i,
  input  wire  [7:0]  cfg_data_i
);
  import ftk_pkg::*;

  localparam int unsigned POS_W  = (MAX_ROW > 2) ? $clog2(MAX_ROW) : 1;
  localparam int unsigned PWIDE  = (POS_W > OPOS_W) ? POS_W : OPOS_W;
  localparam logic [POS_W-1:0]  ROW_LAST = POS_W'(MAX_ROW - 1);
  localparam logic [KCNT_W-1:0] K_MAX    = KCNT_W'(MAX_K);
  localparam logic [KCNT_W-1:0] ONE      = KCNT_W'(1);

  ftk_state_e        state_q, state_d;
  logic [KCNT_W-1:0] k_q;
  logic              sorted_q;
  logic [KCNT_W-1:0] filled_q;
  logic [POS_W-1:0]  row_q;
  logic [KCNT_W-1:0] cnt_q;
  logic [KCNT_W-1:0] round_q;
  logic              odd_q;

  logic [KCNT_W-1:0] k_eff;
  logic [KCNT_W-1:0] n_cur;
  logic [KCNT_W-1:0] n_new;
  logic              in_acc;
  logic              out_acc;
  ftk_ctrl_t         ctrl;
  logic [PWIDE-1:0]  pos_wide;

  logic [15:0]       c_value  [MAX_K];
  logic [POS_W-1:0]  c_pos    [MAX_K];
  logic              c_valid  [MAX_K];
  logic              c_active [MAX_K];
  logic              c_ge     [MAX_K];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= ONE;
      sorted_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_K_COUNT:      k_q      <= cfg_data_i[KCNT_W-1:0];
        REG_SORTED_ORDER: sorted_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Clamp k and count entries after this insertion
  always_comb begin
    if (k_q == '0) begin
      k_eff = ONE;
    end else if (k_q > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = k_q;
    end
    n_cur = (filled_q < k_eff) ? filled_q : k_eff;
    n_new = (n_cur < k_eff) ? n_cur + ONE : k_eff;
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_acc && s_axis_tlast) begin
          state_d = sorted_q ? ST_EMIT : ST_SORT;
        end
      end
      ST_SORT: begin
        if (round_q == ONE) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && cnt_q == ONE) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // Outputs and cell command
  always_comb begin
    s_axis_tready  = 1'b0;
    m_axis_tvalid  = 1'b0;
    ctrl.op        = OP_HOLD;
    ctrl.k_eff     = k_eff;
    ctrl.new_value = s_axis_tdata;
    ctrl.new_key   = rank_key(s_axis_tdata);
    case (state_q)
      ST_COLLECT: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ctrl.op = OP_INSERT;
        end
      end
      ST_SORT: begin
        ctrl.op = odd_q ? OP_SORT_ODD : OP_SORT_EVEN;
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          ctrl.op = OP_SHIFT_OUT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  // Row bookkeeping, sort rounds and result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      row_q    <= '0;
      cnt_q    <= '0;
      round_q  <= '0;
      odd_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        if (s_axis_tlast) begin
          filled_q <= '0;
          row_q    <= '0;
          cnt_q    <= n_new;
          round_q  <= n_new;
          odd_q    <= 1'b0;
        end else begin
          filled_q <= n_new;
          if (row_q < ROW_LAST) begin
            row_q <= row_q + POS_W'(1);
          end
        end
      end
      if (state_q == ST_SORT) begin
        round_q <= round_q - ONE;
        odd_q   <= !odd_q;
      end
      if (out_acc) begin
        cnt_q <= cnt_q - ONE;
      end
    end
  end

  // Chain of cells, best rank at index 0
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic [15:0]      l_value;
    logic [POS_W-1:0] l_pos;
    logic             l_valid;
    logic             l_active;
    logic             l_ge;
    logic [15:0]      r_value;
    logic [POS_W-1:0] r_pos;
    logic             r_valid;

    if (i == 0) begin : g_head
      assign l_value  = '0;
      assign l_pos    = '0;
      assign l_valid  = 1'b0;
      assign l_active = 1'b0;
      assign l_ge     = 1'b1;
    end else begin : g_left
      assign l_value  = c_value[i-1];
      assign l_pos    = c_pos[i-1];
      assign l_valid  = c_valid[i-1];
      assign l_active = c_active[i-1];
      assign l_ge     = c_ge[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign r_value = '0;
      assign r_pos   = '0;
      assign r_valid = 1'b0;
    end else begin : g_right
      assign r_value = c_value[i+1];
      assign r_pos   = c_pos[i+1];
      assign r_valid = c_valid[i+1];
    end

    ftk_cell #(
      .IDX   (i),
      .POS_W (POS_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_pos_i     (row_q),
      .left_value_i  (l_value),
      .left_pos_i    (l_pos),
      .left_valid_i  (l_valid),
      .left_active_i (l_active),
      .left_ge_i     (l_ge),
      .right_value_i (r_value),
      .right_pos_i   (r_pos),
      .right_valid_i (r_valid),
      .value_o       (c_value[i]),
      .pos_o         (c_pos[i]),
      .valid_o       (c_valid[i]),
      .active_o      (c_active[i]),
      .ge_o          (c_ge[i])
    );
  end

  // Present the head cell as the result item
  assign pos_wide     = PWIDE'(c_pos[0]);
  assign m_axis_tdata = {6'b0, pos_wide[OPOS_W-1:0], c_value[0]};
  assign m_axis_tlast = cnt_q == ONE;

endmodule

`default_nettype wire

// ----- rtl/ftk_cell.sv -----
// One cell of the ranked list: holds one entry, inserts, sorts and shifts with neighbors.
`default_nettype none

module ftk_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned POS_W = 10
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  ftk_pkg::ftk_ctrl_t       ctrl_i,
  input  wire  [POS_W-1:0]         new_pos_i,
  // left neighbor (better rank)
  input  wire  [15:0]              left_value_i,
  input  wire  [POS_W-1:0]         left_pos_i,
  input  wire                      left_valid_i,
  input  wire                      left_active_i,
  input  wire                      left_ge_i,
  // right neighbor (worse rank)
  input  wire  [15:0]              right_value_i,
  input  wire  [POS_W-1:0]         right_pos_i,
  input  wire                      right_valid_i,
  // own entry
  output logic [15:0]              value_o,
  output logic [POS_W-1:0]         pos_o,
  output logic                     valid_o,
  output logic                     active_o,
  output logic                     ge_o
);
  import ftk_pkg::*;

  localparam logic [KCNT_W-1:0] IDX_K  = KCNT_W'(IDX);
  localparam bit                IS_EVEN = (IDX % 2) == 0;
  localparam bit                IS_HEAD = IDX == 0;

  logic [VAL_W-1:0] value_q, value_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             valid_q, valid_d;
  logic             in_k;
  logic             take_new;
  logic             take_left;
  logic             pair_right;
  logic             swap_r;
  logic             swap_l;

  // Rank against the incoming element; the newcomer loses ties
  always_comb begin
    in_k     = IDX_K < ctrl_i.k_eff;
    active_o = valid_q && in_k;
    ge_o     = active_o && (rank_key(value_q) >= ctrl_i.new_key);
    take_new  = in_k && !ge_o && left_ge_i;
    take_left = in_k && !left_ge_i && left_active_i;
  end

  // Odd-even transposition pairing, swap only strict position inversions
  always_comb begin
    pair_right = (ctrl_i.op == OP_SORT_EVEN) ? IS_EVEN : !IS_EVEN;
    swap_r     = valid_q && right_valid_i && (pos_q > right_pos_i);
    swap_l     = left_valid_i && valid_q && (left_pos_i > pos_q);
  end

  // Next entry
  always_comb begin
    value_d = value_q;
    pos_d   = pos_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (take_new) begin
          value_d = ctrl_i.new_value;
          pos_d   = new_pos_i;
        end else if (take_left) begin
          value_d = left_value_i;
          pos_d   = left_pos_i;
        end
        valid_d = in_k && (IS_HEAD || left_active_i);
      end
      OP_SORT_EVEN, OP_SORT_ODD: begin
        if (pair_right && swap_r) begin
          value_d = right_value_i;
          pos_d   = right_pos_i;
        end else if (!pair_right && swap_l) begin
          value_d = left_value_i;
          pos_d   = left_pos_i;
        end
      end
      OP_SHIFT_OUT: begin
        value_d = right_value_i;
        pos_d   = right_pos_i;
        valid_d = right_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

  assign value_o = value_q;
  assign pos_o   = pos_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- rtl/ftk_checker.sv -----
// Port-level checks of the top-k selector and their binding to the top level.
`default_nettype none

module ftk_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        s_axis_tlast,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire        m_axis_tlast
);

  // Collection and emission never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !m_axis_tvalid)
    else $error("input item taken while a result is shown");

  // A row end closes the input until results are out
  a_row_end_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after row end");

  // The last result of a row ends emission
  a_run_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("results continue after run end");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind fp16_topk_select_top ftk_checker u_ftk_checker (.*);

`default_nettype wire
